@@ sv/i2cmw_pkg.sv @@
package i2cmw_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_DELAY     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_DELAY    = 2'd2;

  localparam logic [7:0] DEVICE_ADDRESS_RST = 8'd120;
  localparam logic [7:0] LONG_DELAY_RST     = 8'd5;
  localparam logic [7:0] SHORT_DELAY_RST    = 8'd2;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ADDR_NACK = 2'd1,
    ST_REG_NACK  = 2'd2,
    ST_DATA_NACK = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START_A  = 4'd1,
    PH_START_B  = 4'd2,
    PH_BIT_LOW  = 4'd3,
    PH_BIT_HIGH = 4'd4,
    PH_ACK_LOW  = 4'd5,
    PH_ACK_HIGH = 4'd6,
    PH_STOP_A   = 4'd7,
    PH_STOP_B   = 4'd8
  } phase_t;

  // classified input beat
  typedef struct packed {
    logic       start;
    logic [7:0] register_byte;
    logic [7:0] data_byte;
    logic       sda_level;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_out_level;
    logic       sda_driving;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } res_item_t;

  function automatic logic [7:0] at_least_one(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

@@ sv/i2cmw_fifo.sv @@
module i2cmw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ sv/i2cmw_engine.sv @@
module i2cmw_engine (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [i2cmw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [i2cmw_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                  item_valid,
  input  i2cmw_pkg::in_item_t                   item,
  output logic                                  item_take,
  input  logic                                  res_full,
  output logic                                  res_push,
  output i2cmw_pkg::res_item_t                  res
);

  logic [7:0] device_address;
  logic [7:0] long_delay_ticks;
  logic [7:0] short_delay_ticks;

  i2cmw_pkg::phase_t phase, phase_next;
  logic [7:0] delay_count, delay_count_next;
  logic [2:0] bit_index, bit_index_next;
  logic [1:0] byte_index, byte_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] held_register, held_register_next;
  logic [7:0] held_data, held_data_next;
  logic [1:0] last_status, last_status_next;

  logic       fire;
  logic       load;
  logic       done;
  logic [7:0] dec;
  logic [1:0] nack_status;

  assign fire      = item_valid && !res_full;
  assign item_take = fire;
  assign res_push  = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address    <= i2cmw_pkg::DEVICE_ADDRESS_RST;
      long_delay_ticks  <= i2cmw_pkg::LONG_DELAY_RST;
      short_delay_ticks <= i2cmw_pkg::SHORT_DELAY_RST;
    end else if (cfg_we) begin
      priority case (cfg_index)
        i2cmw_pkg::REG_DEVICE_ADDRESS: device_address    <= cfg_data;
        i2cmw_pkg::REG_LONG_DELAY:     long_delay_ticks  <= cfg_data;
        i2cmw_pkg::REG_SHORT_DELAY:    short_delay_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= i2cmw_pkg::PH_IDLE;
      delay_count   <= '0;
      bit_index     <= '0;
      byte_index    <= '0;
      shift_byte    <= '0;
      held_register <= '0;
      held_data     <= '0;
      last_status   <= i2cmw_pkg::ST_OK;
    end else if (fire) begin
      phase         <= phase_next;
      delay_count   <= delay_count_next;
      bit_index     <= bit_index_next;
      byte_index    <= byte_index_next;
      shift_byte    <= shift_byte_next;
      held_register <= held_register_next;
      held_data     <= held_data_next;
      last_status   <= last_status_next;
    end
  end

  always_comb begin
    unique case (byte_index)
      2'd0:    nack_status = i2cmw_pkg::ST_ADDR_NACK;
      2'd1:    nack_status = i2cmw_pkg::ST_REG_NACK;
      2'd2:    nack_status = i2cmw_pkg::ST_DATA_NACK;
      default: nack_status = i2cmw_pkg::ST_OK;
    endcase
  end

  always_comb begin
    phase_next         = phase;
    delay_count_next   = delay_count;
    bit_index_next     = bit_index;
    byte_index_next    = byte_index;
    shift_byte_next    = shift_byte;
    held_register_next = held_register;
    held_data_next     = held_data;
    last_status_next   = last_status;
    load               = 1'b0;
    done               = 1'b0;
    dec                = delay_count - 8'd1;

    if (phase == i2cmw_pkg::PH_IDLE) begin
      if (item.start) begin
        held_register_next = item.register_byte;
        held_data_next     = item.data_byte;
        last_status_next   = i2cmw_pkg::ST_OK;
        byte_index_next    = '0;
        bit_index_next     = '0;
        shift_byte_next    = device_address;
        phase_next         = i2cmw_pkg::PH_START_A;
        load               = 1'b1;
      end
    end else begin
      delay_count_next = dec;
      if (dec == 8'd0) begin
        load = 1'b1;
        unique case (phase)
          i2cmw_pkg::PH_START_A: phase_next = i2cmw_pkg::PH_START_B;
          i2cmw_pkg::PH_START_B: phase_next = i2cmw_pkg::PH_BIT_LOW;
          i2cmw_pkg::PH_BIT_LOW: phase_next = i2cmw_pkg::PH_BIT_HIGH;
          i2cmw_pkg::PH_BIT_HIGH: begin
            shift_byte_next = {shift_byte[6:0], 1'b0};
            if (bit_index == 3'd7) begin
              bit_index_next = '0;
              phase_next     = i2cmw_pkg::PH_ACK_LOW;
            end else begin
              bit_index_next = bit_index + 3'd1;
              phase_next     = i2cmw_pkg::PH_BIT_LOW;
            end
          end
          i2cmw_pkg::PH_ACK_LOW: phase_next = i2cmw_pkg::PH_ACK_HIGH;
          i2cmw_pkg::PH_ACK_HIGH: begin
            if (item.sda_level) begin
              last_status_next = nack_status;
              phase_next       = i2cmw_pkg::PH_STOP_A;
            end else if (byte_index >= 2'd2) begin
              last_status_next = i2cmw_pkg::ST_OK;
              phase_next       = i2cmw_pkg::PH_STOP_A;
            end else begin
              byte_index_next = byte_index + 2'd1;
              shift_byte_next = (byte_index == 2'd0) ? held_register : held_data;
              bit_index_next  = '0;
              phase_next      = i2cmw_pkg::PH_BIT_LOW;
            end
          end
          i2cmw_pkg::PH_STOP_A: phase_next = i2cmw_pkg::PH_STOP_B;
          default: begin
            done       = 1'b1;
            phase_next = i2cmw_pkg::PH_IDLE;
          end
        endcase
      end
    end

    if (load) begin
      unique case (phase_next)
        i2cmw_pkg::PH_IDLE:     delay_count_next = '0;
        i2cmw_pkg::PH_BIT_LOW,
        i2cmw_pkg::PH_BIT_HIGH: delay_count_next = i2cmw_pkg::at_least_one(short_delay_ticks);
        default:                delay_count_next = i2cmw_pkg::at_least_one(long_delay_ticks);
      endcase
    end
  end

  // line levels follow the phase after the step
  always_comb begin
    res.busy_res = (phase_next != i2cmw_pkg::PH_IDLE);
    res.done_res = done;
    res.status   = last_status_next;
    unique case (phase_next)
      i2cmw_pkg::PH_START_B,
      i2cmw_pkg::PH_STOP_B: begin
        res.scl_level = 1'b1; res.sda_out_level = 1'b0; res.sda_driving = 1'b1;
      end
      i2cmw_pkg::PH_STOP_A: begin
        res.scl_level = 1'b0; res.sda_out_level = 1'b0; res.sda_driving = 1'b1;
      end
      i2cmw_pkg::PH_BIT_LOW: begin
        res.scl_level = 1'b0; res.sda_out_level = shift_byte_next[7]; res.sda_driving = 1'b1;
      end
      i2cmw_pkg::PH_BIT_HIGH: begin
        res.scl_level = 1'b1; res.sda_out_level = shift_byte_next[7]; res.sda_driving = 1'b1;
      end
      i2cmw_pkg::PH_ACK_LOW: begin
        res.scl_level = 1'b0; res.sda_out_level = 1'b1; res.sda_driving = 1'b0;
      end
      i2cmw_pkg::PH_ACK_HIGH: begin
        res.scl_level = 1'b1; res.sda_out_level = 1'b1; res.sda_driving = 1'b0;
      end
      default: begin
        res.scl_level = 1'b1; res.sda_out_level = 1'b1; res.sda_driving = 1'b1;
      end
    endcase
  end

endmodule

@@ sv/i2c_master_register_write.sv @@
// Bit-level I2C master playing one register write: start, address byte,
// register byte, data byte, stop, with an acknowledge slot after each byte.
// Input queue: push/full. Each beat is one bus time tick; a beat with
// command = 1 also starts a transaction when the engine is idle (ignored
// while busy). sda_level carries the sampled data line for that tick.
// Result queue: empty/pop. Every input beat yields exactly one result beat
// with the line levels for that tick, busy, the done pulse and status.
// Config port: cfg_we/cfg_index/cfg_data; write only while idle.
// Path: a pushed beat is registered in the input queue, and the engine
// steps it out of the input queue into the registered result queue.
// Throughput: one beat and tick per cycle while the result queue has room.
// Reset: both queues empty, engine idle, registers at address 120, long
// delay 5, short delay 2, status ok.
// Receiver stall: results collect in the result queue (QUEUE_DEPTH beats),
// then the engine stops and the input queue fills; full rises after
// 2*QUEUE_DEPTH unread beats. Only pushes made while full are lost.
module i2c_master_register_write #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [i2cmw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [i2cmw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              push,
  output logic                              full,
  input  logic                              command,
  input  logic [7:0]                        register_byte,
  input  logic [7:0]                        data_byte,
  input  logic                              sda_level,
  output logic                              empty,
  input  logic                              pop,
  output logic                              scl_level,
  output logic                              sda_out_level,
  output logic                              sda_driving,
  output logic                              busy_res,
  output logic                              done_res,
  output logic [1:0]                        status
);

  localparam int IN_W  = $bits(i2cmw_pkg::in_item_t);
  localparam int RES_W = $bits(i2cmw_pkg::res_item_t);

  i2cmw_pkg::in_item_t  in_beat;
  i2cmw_pkg::in_item_t  eng_item;
  i2cmw_pkg::res_item_t eng_res;
  i2cmw_pkg::res_item_t out_res;
  logic [IN_W-1:0]      in_q_data;
  logic [RES_W-1:0]     out_q_data;
  logic                 in_q_empty;
  logic                 eng_take;
  logic                 res_full;
  logic                 res_push;

  // front: classify the beat
  always_comb begin
    in_beat.start         = (command == i2cmw_pkg::CMD_START);
    in_beat.register_byte = register_byte;
    in_beat.data_byte     = data_byte;
    in_beat.sda_level     = sda_level;
  end

  i2cmw_fifo #(.WIDTH(IN_W), .DEPTH(QUEUE_DEPTH)) u_in_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (in_beat),
    .full    (full),
    .rd_en   (eng_take),
    .rd_data (in_q_data),
    .empty   (in_q_empty)
  );

  assign eng_item = i2cmw_pkg::in_item_t'(in_q_data);

  i2cmw_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (!in_q_empty),
    .item       (eng_item),
    .item_take  (eng_take),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (eng_res)
  );

  i2cmw_fifo #(.WIDTH(RES_W), .DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (eng_res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_q_data),
    .empty   (empty)
  );

  assign out_res       = i2cmw_pkg::res_item_t'(out_q_data);
  assign scl_level     = out_res.scl_level;
  assign sda_out_level = out_res.sda_out_level;
  assign sda_driving   = out_res.sda_driving;
  assign busy_res      = out_res.busy_res;
  assign done_res      = out_res.done_res;
  assign status        = out_res.status;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (!empty && done_res) |-> (!busy_res && scl_level && sda_out_level && sda_driving))
    else $error("done beat not in idle line state");

  // a nack status while busy only shows during the closing stop condition
  a_busy_status: assert property (@(posedge clk) disable iff (rst)
    (!empty && busy_res && status != i2cmw_pkg::ST_OK) |-> (sda_driving && !sda_out_level))
    else $error("nack status outside stop condition");

  a_released_high: assert property (@(posedge clk) disable iff (rst)
    (!empty && !sda_driving) |-> (sda_out_level && busy_res))
    else $error("released data line outside ack slot");

  a_engine_source: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (!in_q_empty && !res_full))
    else $error("engine stepped without a beat or room");

endmodule
